### hdl/jssd_pkg.sv
// Shared constants for the job-shop schedule decoder.
// No dependencies; used by the channel interfaces and the top level.
package jssd_pkg;

  localparam int MAX_MACHINES = 64;
  localparam int MAX_JOBS     = 64;
  localparam int TIME_BITS    = 32;

  // Field widths on the channels.
  localparam int MACH_IDX_W = 6;
  localparam int JOB_IDX_W  = 6;
  localparam int DUR_W      = 16;
  localparam int OUT_TIME_W = 32;

  // Table address widths.
  localparam int MACH_AW = $clog2(MAX_MACHINES);
  localparam int JOB_AW  = $clog2(MAX_JOBS);

  // Internal time width: capped by the 32-bit result fields.
  localparam int TIME_W = (TIME_BITS < OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;
  localparam logic [TIME_W-1:0] TIME_LIMIT = {TIME_W{1'b1}};

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [MACH_AW-1:0] mach_addr_t;
  typedef logic [JOB_AW-1:0]  job_addr_t;

endpackage

### hdl/jssd_if.sv
// Valid/ready channel interfaces for the job-shop schedule decoder.
// Depends on jssd_pkg for field widths.
interface jssd_in_if;
  logic                             valid;
  logic                             ready;
  logic                             restart;
  logic [jssd_pkg::MACH_IDX_W-1:0]  machine_index;
  logic [jssd_pkg::JOB_IDX_W-1:0]   job_index;
  logic [jssd_pkg::DUR_W-1:0]       duration;

  modport source (output valid, restart, machine_index, job_index, duration, input ready);
  modport sink   (input valid, restart, machine_index, job_index, duration, output ready);
endinterface

interface jssd_out_if;
  logic                             valid;
  logic                             ready;
  logic [jssd_pkg::OUT_TIME_W-1:0]  start_time;
  logic [jssd_pkg::OUT_TIME_W-1:0]  end_time;
  logic [jssd_pkg::OUT_TIME_W-1:0]  makespan;
  logic                             overflow;

  modport source (output valid, start_time, end_time, makespan, overflow, input ready);
  modport sink   (input valid, start_time, end_time, makespan, overflow, output ready);
endinterface

### hdl/job_shop_schedule_decoder.sv
// Job-shop semi-active schedule decoder: top level with free-time tables.
// Depends on jssd_pkg and the channel interfaces in jssd_if.sv.
//
//   channel   dir   handshake              payload
//   in_chan   in    valid/ready (request)  restart, machine_index, job_index, duration
//   out_chan  out   valid/ready (request)  start_time, end_time, makespan, overflow
//
// One request per cycle sustained while out_chan is not stalled; out_chan.valid rises
// once the request has passed stage 1 and been loaded into the output register.
// The machine and job free-time memories are read on accept into registered outputs;
// stage 1 then picks the later time, adds the duration, writes both tables back and
// loads the output register. Back-to-back hits on the same entry are forwarded.
// Reset and restart clear the valid flops at once; no clearing pass is needed.
// A stall on out_chan holds the output register and backs up through stage 1.
module job_shop_schedule_decoder (
  input  logic         clk,
  input  logic         rst_n,
  jssd_in_if.sink      in_chan,
  jssd_out_if.source   out_chan
);

  // ---------------------------------------------------------------------------
  // Free-time memories and valid flops
  // ---------------------------------------------------------------------------
  jssd_pkg::time_t mach_mem [jssd_pkg::MAX_MACHINES];
  jssd_pkg::time_t job_mem  [jssd_pkg::MAX_JOBS];
  jssd_pkg::time_t mach_rd_r;
  jssd_pkg::time_t job_rd_r;

  logic [jssd_pkg::MAX_MACHINES-1:0] mach_valid_r;
  logic [jssd_pkg::MAX_JOBS-1:0]     job_valid_r;
  logic [jssd_pkg::MAX_MACHINES-1:0] mach_valid_nxt;
  logic [jssd_pkg::MAX_JOBS-1:0]     job_valid_nxt;

  // ---------------------------------------------------------------------------
  // Stage 1 (compute) registers
  // ---------------------------------------------------------------------------
  logic                       s1_valid_r;
  logic                       s1_restart_r;
  jssd_pkg::mach_addr_t       s1_mach_r;
  jssd_pkg::job_addr_t        s1_job_r;
  logic [jssd_pkg::DUR_W-1:0] s1_dur_r;
  logic                       s1_mach_fwd_r;
  logic                       s1_job_fwd_r;
  jssd_pkg::time_t            fwd_time_r;

  jssd_pkg::time_t makespan_r;

  // Output register
  logic                            out_valid_r;
  logic [jssd_pkg::OUT_TIME_W-1:0] out_start_r;
  logic [jssd_pkg::OUT_TIME_W-1:0] out_end_r;
  logic [jssd_pkg::OUT_TIME_W-1:0] out_ms_r;
  logic                            out_ovf_r;

  logic                 in_acc;
  logic                 s1_adv;
  jssd_pkg::mach_addr_t in_mach;
  jssd_pkg::job_addr_t  in_job;

  jssd_pkg::time_t  mach_time;
  jssd_pkg::time_t  job_time;
  jssd_pkg::time_t  start_time;
  logic [jssd_pkg::TIME_W:0] end_sum;
  logic             ovf;
  jssd_pkg::time_t  end_time;
  jssd_pkg::time_t  ms_base;
  jssd_pkg::time_t  ms_nxt;

  // Stage 1 leaves when the output register is empty or being drained.
  assign s1_adv = s1_valid_r && (!out_valid_r || out_chan.ready);
  // Take a new request whenever stage 1 is free or moving on this cycle.
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Table sizes are powers of two: the low index bits are the address.
  assign in_mach = in_chan.machine_index[jssd_pkg::MACH_AW-1:0];
  assign in_job  = in_chan.job_index[jssd_pkg::JOB_AW-1:0];

  // Read the tables on accept; write back the stage 1 result as it leaves.
  // A read and a write to the same entry in one cycle returns the old data,
  // so the fresh value is forwarded instead.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mach_rd_r <= mach_mem[in_mach];
      job_rd_r  <= job_mem[in_job];
    end
    if (s1_adv) begin
      mach_mem[s1_mach_r] <= end_time;
      job_mem[s1_job_r]   <= end_time;
    end
  end

  // Valid flops: set on writeback, clear on restart (clear wins, since the
  // older operation it overrides belongs to the previous sequence).
  always_comb begin
    priority if (in_acc && in_chan.restart) begin
      mach_valid_nxt = '0;
      job_valid_nxt  = '0;
    end else if (s1_adv) begin
      mach_valid_nxt            = mach_valid_r;
      job_valid_nxt             = job_valid_r;
      mach_valid_nxt[s1_mach_r] = 1'b1;
      job_valid_nxt[s1_job_r]   = 1'b1;
    end else begin
      mach_valid_nxt = mach_valid_r;
      job_valid_nxt  = job_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mach_valid_r <= '0;
      job_valid_r  <= '0;
    end else begin
      mach_valid_r <= mach_valid_nxt;
      job_valid_r  <= job_valid_nxt;
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload; forward flags mark a hit on the entry written this cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_restart_r  <= in_chan.restart;
      s1_mach_r     <= in_mach;
      s1_job_r      <= in_job;
      s1_dur_r      <= in_chan.duration;
      s1_mach_fwd_r <= s1_adv && !in_chan.restart && (s1_mach_r == in_mach);
      s1_job_fwd_r  <= s1_adv && !in_chan.restart && (s1_job_r == in_job);
      fwd_time_r    <= end_time;
    end
  end

  // Pick each free time: forwarded, stored, or zero for an unwritten entry.
  always_comb begin
    if (s1_mach_fwd_r) begin
      mach_time = fwd_time_r;
    end else if (mach_valid_r[s1_mach_r]) begin
      mach_time = mach_rd_r;
    end else begin
      mach_time = '0;
    end
    if (s1_job_fwd_r) begin
      job_time = fwd_time_r;
    end else if (job_valid_r[s1_job_r]) begin
      job_time = job_rd_r;
    end else begin
      job_time = '0;
    end
  end

  // Start at the later free time; saturate the end time at the limit.
  assign start_time = (mach_time > job_time) ? mach_time : job_time;
  assign end_sum    = {1'b0, start_time} + (jssd_pkg::TIME_W + 1)'(s1_dur_r);
  assign ovf        = end_sum > {1'b0, jssd_pkg::TIME_LIMIT};
  assign end_time   = ovf ? jssd_pkg::TIME_LIMIT : end_sum[jssd_pkg::TIME_W-1:0];

  // Running makespan restarts with the sequence.
  assign ms_base = s1_restart_r ? '0 : makespan_r;
  assign ms_nxt  = (end_time > ms_base) ? end_time : ms_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      makespan_r <= '0;
    end else if (s1_adv) begin
      makespan_r <= ms_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_start_r <= jssd_pkg::OUT_TIME_W'(start_time);
      out_end_r   <= jssd_pkg::OUT_TIME_W'(end_time);
      out_ms_r    <= jssd_pkg::OUT_TIME_W'(ms_nxt);
      out_ovf_r   <= ovf;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.start_time = out_start_r;
  assign out_chan.end_time   = out_end_r;
  assign out_chan.makespan   = out_ms_r;
  assign out_chan.overflow   = out_ovf_r;

`ifndef SYNTHESIS
  // An accepted request always lands in stage 1.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted request did not reach stage 1");

  // A restart leaves every table entry unwritten on the next cycle.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.restart) |=> (mach_valid_r == '0 && job_valid_r == '0))
    else $error("restart did not clear valid flops");

  // Overflow only with a saturated end time.
  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |->
      (out_end_r == jssd_pkg::OUT_TIME_W'(jssd_pkg::TIME_LIMIT)))
    else $error("overflow without saturated end time");

  // The makespan covers this result's end, which covers its start.
  a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ms_r >= out_end_r && out_end_r >= out_start_r))
    else $error("start, end and makespan out of order");
`endif

endmodule
